/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int CELL_W = 16;

   // command codes
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // character codes
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_BLANK     = 8'd32;

   // register map: index taken from paddr[2]
   localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

   localparam logic [7:0]        ATTR_RESET = 8'h07;
   localparam logic [CELL_W-1:0] INIT_CELL  = 16'h0720;

   // request to the screen sweep engine
   typedef struct packed {
      logic              go;
      logic              copy;   // 1: move rows up and blank the last row
      logic [CELL_W-1:0] fill;
   } sweep_cmd_type;

endpackage

/* src/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* src/tcw_sweep.sv */
// ----------------------------------------------------------------------------
// tcw_sweep
// Walks the whole screen once, one cell a cycle. In copy mode each cell takes
// the cell one row below (read in the cycle before its write) and the last row
// gets the fill value; otherwise every cell gets the fill value.
// ----------------------------------------------------------------------------
module tcw_sweep
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int CELLS   = 2000
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sweep_cmd_type            cmd,
   output logic                     busy,
   output logic                     rd_en,
   output logic [$clog2(CELLS)-1:0] rd_addr,
   input  logic [CELL_W-1:0]        rd_data,
   output logic                     wr_en,
   output logic [$clog2(CELLS)-1:0] wr_addr,
   output logic [CELL_W-1:0]        wr_data
);

   localparam int AW          = $clog2(CELLS);
   localparam int COPY_CELLS  = CELLS - COLUMNS;

   logic              active_ff;
   logic [AW-1:0]     cnt_ff;
   logic              copy_ff;
   logic [CELL_W-1:0] fill_ff;
   logic              wv_ff;
   logic [AW-1:0]     wa_ff;
   logic              wcopy_ff;
   logic              src_ok;
   logic [AW:0]       src_sum;

   assign src_ok  = (32'(cnt_ff) < COPY_CELLS);
   assign src_sum = {1'b0, cnt_ff} + (AW+1)'(COLUMNS);

   assign rd_en   = active_ff && copy_ff && src_ok;
   assign rd_addr = src_sum[AW-1:0];
   assign wr_en   = wv_ff;
   assign wr_addr = wa_ff;
   assign wr_data = wcopy_ff ? rd_data : fill_ff;
   assign busy    = active_ff | wv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         wv_ff     <= 1'b0;
      end else begin
         wv_ff <= active_ff;
         if (cmd.go) begin
            active_ff <= 1'b1;
         end else if (active_ff && cnt_ff == AW'(CELLS - 1)) begin
            active_ff <= 1'b0;
         end
      end
      if (cmd.go) begin
         cnt_ff  <= '0;
         copy_ff <= cmd.copy;
         fill_ff <= cmd.fill;
      end else if (active_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      wa_ff    <= cnt_ff;
      wcopy_ff <= copy_ff && src_ok;
   end

endmodule

/* src/text_console_char_writer.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text screen of 16-bit cells with a cursor: put character, clear, read cell.
//
//   channel   handshake          payload
//   request   start / busy       req_cmd, req_char_code, req_read_index
//   result    rsp_valid          rsp_cursor_column, rsp_cursor_line,
//                                rsp_cursor_position, rsp_did_scroll,
//                                rsp_cell_value
//   csr       psel/penable/...   paddr, pwdata, prdata (text_attribute)
//
// Put without scroll, unused command and out-of-range read strobe the result
// from the execute state; an in-range read strobes it from the read state.
// Scroll and clear sweep the screen once through the RAM port pair. After
// reset a clearing pass holds busy high. busy is high from the accepting edge
// until the strobe; the result is shown for one cycle with busy low.
// ----------------------------------------------------------------------------
module text_console_char_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_read_index,
   output logic        rsp_valid,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_line,
   output logic [10:0] rsp_cursor_position,
   output logic        rsp_did_scroll,
   output logic [15:0] rsp_cell_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_WAIT
   } state_type;

   state_type         state_ff;
   logic [RW-1:0]     row_ff;
   logic [CW-1:0]     col_ff;
   logic [7:0]        attr_ff;
   logic [1:0]        cmd_ff;
   logic [7:0]        char_ff;
   logic [10:0]       ridx_ff;
   logic              rsp_valid_ff;
   logic              rsp_pend_ff;
   logic              did_scroll_ff;
   logic [CELL_W-1:0] cell_ff;

   // cursor step
   logic [RW:0]       row_in;
   logic [CW:0]       col_in;
   logic [RW-1:0]     tgt_row;
   logic [CW-1:0]     tgt_col;
   logic              put_we;
   logic [CELL_W-1:0] put_data;
   logic              scroll;
   logic [RW-1:0]     row_fin;
   logic [AW-1:0]     put_addr;
   logic              read_ok;
   logic [CELL_W-1:0] blank;

   // memory ports
   sweep_cmd_type     sweep_cmd;
   logic              sw_busy;
   logic              sw_re;
   logic [AW-1:0]     sw_ra;
   logic              sw_we;
   logic [AW-1:0]     sw_wa;
   logic [CELL_W-1:0] sw_wd;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [CELL_W-1:0] mem_wd;
   logic              mem_re;
   logic [AW-1:0]     mem_ra;
   logic [CELL_W-1:0] mem_rd;
   logic              csr_write;

   assign blank = {attr_ff, CH_BLANK};

   always_comb begin
      row_in   = {1'b0, row_ff};
      col_in   = {1'b0, col_ff};
      tgt_row  = row_ff;
      tgt_col  = col_ff;
      put_we   = 1'b0;
      put_data = {attr_ff, char_ff};
      if (char_ff == CH_NEWLINE) begin
         col_in = '0;
         row_in = {1'b0, row_ff} + 1'b1;
      end else if (char_ff == CH_BACKSPACE) begin
         if (col_ff == '0) begin
            if (row_ff != '0) begin
               row_in = {1'b0, row_ff} - 1'b1;
               col_in = (CW+1)'(COLUMNS - 1);
            end
         end else begin
            col_in = {1'b0, col_ff} - 1'b1;
         end
         tgt_row  = row_in[RW-1:0];
         tgt_col  = col_in[CW-1:0];
         put_we   = 1'b1;
         put_data = blank;
      end else begin
         col_in = {1'b0, col_ff} + 1'b1;
         put_we = 1'b1;
      end
      if (col_in >= (CW+1)'(COLUMNS)) begin
         col_in = '0;
         row_in = row_in + 1'b1;
      end
      scroll  = (row_in >= (RW+1)'(ROWS));
      row_fin = scroll ? RW'(ROWS - 1) : row_in[RW-1:0];
   end

   assign put_addr = AW'(32'(tgt_row) * COLUMNS) + AW'(tgt_col);
   assign read_ok  = (32'(ridx_ff) < CELLS);

   always_comb begin
      sweep_cmd = '{go: 1'b0, copy: 1'b0, fill: blank};
      case (state_ff)
         ST_INIT: begin
            sweep_cmd.go   = 1'b1;
            sweep_cmd.fill = INIT_CELL;
         end
         ST_EXEC: begin
            if (cmd_ff == CMD_CLEAR) begin
               sweep_cmd.go = 1'b1;
            end else if (cmd_ff == CMD_PUT && scroll) begin
               sweep_cmd.go   = 1'b1;
               sweep_cmd.copy = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // put write and cell read only in the execute state; sweep owns the ports otherwise
   always_comb begin
      mem_we = sw_we;
      mem_wa = sw_wa;
      mem_wd = sw_wd;
      mem_re = sw_re;
      mem_ra = sw_ra;
      if (state_ff == ST_EXEC && cmd_ff == CMD_PUT && put_we) begin
         mem_we = 1'b1;
         mem_wa = put_addr;
         mem_wd = put_data;
      end
      if (state_ff == ST_EXEC && cmd_ff == CMD_READ && read_ok) begin
         mem_re = 1'b1;
         mem_ra = AW'(ridx_ff);
      end
   end

   tcw_sweep #(
      .COLUMNS (COLUMNS),
      .CELLS   (CELLS)
   ) u_sweep (
      .clock   (clock),
      .reset   (reset),
      .cmd     (sweep_cmd),
      .busy    (sw_busy),
      .rd_en   (sw_re),
      .rd_addr (sw_ra),
      .rd_data (mem_rd),
      .wr_en   (sw_we),
      .wr_addr (sw_wa),
      .wr_data (sw_wd)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTRIBUTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
         rsp_pend_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            attr_ff <= pwdata[7:0];
         end
         case (state_ff)
            ST_INIT: begin
               rsp_pend_ff <= 1'b0;
               state_ff    <= ST_WAIT;
            end
            ST_IDLE: begin
               if (start) begin
                  cmd_ff   <= req_cmd;
                  char_ff  <= req_char_code;
                  ridx_ff  <= req_read_index;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               did_scroll_ff <= 1'b0;
               cell_ff       <= '0;
               rsp_pend_ff   <= 1'b1;
               case (cmd_ff)
                  CMD_PUT: begin
                     row_ff        <= row_fin;
                     col_ff        <= col_in[CW-1:0];
                     did_scroll_ff <= scroll;
                     if (scroll) begin
                        state_ff <= ST_WAIT;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  CMD_CLEAR: begin
                     row_ff   <= '0;
                     col_ff   <= '0;
                     state_ff <= ST_WAIT;
                  end
                  CMD_READ: begin
                     if (read_ok) begin
                        state_ff <= ST_READ;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  default: begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               endcase
            end
            ST_READ: begin
               cell_ff      <= mem_rd;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_WAIT: begin
               if (!sw_busy) begin
                  rsp_valid_ff <= rsp_pend_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_column   = 7'(col_ff);
   assign rsp_cursor_line     = 5'(row_ff);
   assign rsp_cursor_position = 11'(32'(row_ff) * COLUMNS + 32'(col_ff));
   assign rsp_did_scroll      = did_scroll_ff;
   assign rsp_cell_value      = cell_ff;
   assign prdata = (paddr[2] == REG_TEXT_ATTRIBUTE) ? {24'd0, attr_ff} : 32'd0;
   assign pready = 1'b1;

endmodule

/* src/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the text console character writer, bound to the top.
// ----------------------------------------------------------------------------
module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [6:0]  rsp_cursor_column,
   input logic [4:0]  rsp_cursor_line,
   input logic [10:0] rsp_cursor_position,
   input logic        rsp_did_scroll
);

   // an accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low right after an accepted request");

   // a result is shown with the block ready again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_scroll_bottom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_did_scroll |-> rsp_cursor_line == 5'(ROWS - 1))
      else $error("scroll left cursor off the bottom row");

   a_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ROWS > 32) ||
         rsp_cursor_position == 11'(32'(rsp_cursor_line) * COLUMNS
                                    + 32'(rsp_cursor_column)))
      else $error("linear cursor position does not match row and column");

endmodule

bind text_console_char_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (.*);

/* test/text_console_char_writer_checker.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer_checker
// Watches the request, result and csr channels of the console writer. It keeps
// its own screen image, cursor and attribute, predicts one report per accepted
// request and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module text_console_char_writer_checker
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_read_index,
   input  logic        rsp_valid,
   input  logic [6:0]  rsp_cursor_column,
   input  logic [4:0]  rsp_cursor_line,
   input  logic [10:0] rsp_cursor_position,
   input  logic        rsp_did_scroll,
   input  logic [15:0] rsp_cell_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int unsigned fail_count,
   output int unsigned expected_left
);

   localparam int CELLS = COLUMNS * ROWS;

   typedef struct packed {
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_line;
      logic [10:0] cursor_position;
      logic        did_scroll;
      logic [15:0] cell_value;
   } console_report_type;

   logic [CELL_W-1:0]  screen_image [CELLS];
   int                 cursor_row;
   int                 cursor_col;
   logic [7:0]         attribute;
   console_report_type expected_reports [$];

   task automatic advance_console(input logic [1:0] cmd, input logic [7:0] ch,
                                  input logic [10:0] index,
                                  output console_report_type report);
      logic [CELL_W-1:0] blank;
      logic              scrolled;
      logic [15:0]       read_value;
      int                position;
      blank      = {attribute, CH_BLANK};
      scrolled   = 1'b0;
      read_value = '0;
      case (cmd)
         CMD_PUT: begin
            if (ch == CH_NEWLINE) begin
               cursor_col = 0;
               cursor_row++;
            end else if (ch == CH_BACKSPACE) begin
               // at home nothing moves, cell 0 still gets blanked
               if (cursor_col == 0) begin
                  if (cursor_row > 0) begin
                     cursor_row--;
                     cursor_col = COLUMNS - 1;
                  end
               end else begin
                  cursor_col--;
               end
               screen_image[cursor_row * COLUMNS + cursor_col] = blank;
            end else begin
               screen_image[cursor_row * COLUMNS + cursor_col] = {attribute, ch};
               cursor_col++;
            end
            if (cursor_col >= COLUMNS) begin
               cursor_col = 0;
               cursor_row++;
            end
            if (cursor_row >= ROWS) begin
               for (int i = 0; i + COLUMNS < CELLS; i++)
                  screen_image[i] = screen_image[i + COLUMNS];
               for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                  screen_image[i] = blank;
               cursor_row = ROWS - 1;
               scrolled   = 1'b1;
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen_image[i] = blank;
            cursor_row = 0;
            cursor_col = 0;
         end
         CMD_READ: begin
            if (index < CELLS)
               read_value = screen_image[index];
         end
         default: ;
      endcase
      position                = cursor_row * COLUMNS + cursor_col;
      report.cursor_column   = cursor_col[6:0];
      report.cursor_line     = cursor_row[4:0];
      report.cursor_position = position[10:0];
      report.did_scroll      = scrolled;
      report.cell_value      = read_value;
   endtask

   task automatic compare_field(input string field_name, input logic [15:0] expected,
                                input logic [15:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, actual %0d", field_name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      console_report_type report;
      if (reset) begin
         for (int i = 0; i < CELLS; i++)
            screen_image[i] = INIT_CELL;
         cursor_row = 0;
         cursor_col = 0;
         attribute  = ATTR_RESET;
         expected_reports.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_reports.size() == 0) begin
               $error("result strobed with no request outstanding");
               fail_count++;
            end else begin
               report = expected_reports.pop_front();
               compare_field("cursor_column", 16'(report.cursor_column), 16'(rsp_cursor_column));
               compare_field("cursor_line", 16'(report.cursor_line), 16'(rsp_cursor_line));
               compare_field("cursor_position", 16'(report.cursor_position),
                             16'(rsp_cursor_position));
               compare_field("did_scroll", 16'(report.did_scroll), 16'(rsp_did_scroll));
               compare_field("cell_value", report.cell_value, rsp_cell_value);
            end
         end
         if (start && !busy) begin
            advance_console(req_cmd, req_char_code, req_read_index, report);
            expected_reports.push_back(report);
         end
         if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_ATTRIBUTE)
            attribute = pwdata[7:0];
      end
      expected_left = expected_reports.size();
   end

endmodule

/* test/text_console_char_writer_tb.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer_tb
// Drives put, clear, read and unused requests with random gaps, rewrites the text
// attribute between phases and lets the checker compare every result.
// ----------------------------------------------------------------------------
module text_console_char_writer_tb;
   import tcw_pkg::*;

   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int CLOCK_PERIOD = 12;
   localparam int PHASE_ITEMS  = 266;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [7:0]  req_char_code;
   logic [10:0] req_read_index;
   logic        rsp_valid;
   logic [6:0]  rsp_cursor_column;
   logic [4:0]  rsp_cursor_line;
   logic [10:0] rsp_cursor_position;
   logic        rsp_did_scroll;
   logic [15:0] rsp_cell_value;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int unsigned fail_count;
   int unsigned expected_left;
   int unsigned accepted_count = 0;
   int unsigned result_count   = 0;
   int unsigned item_count     = 0;
   int unsigned burst_left     = 0;
   logic [10:0] last_position  = '0;

   text_console_char_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_char_code       (req_char_code),
      .req_read_index      (req_read_index),
      .rsp_valid           (rsp_valid),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cursor_line     (rsp_cursor_line),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_did_scroll      (rsp_did_scroll),
      .rsp_cell_value      (rsp_cell_value),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   text_console_char_writer_checker #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) report_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_char_code       (req_char_code),
      .req_read_index      (req_read_index),
      .rsp_valid           (rsp_valid),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cursor_line     (rsp_cursor_line),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_did_scroll      (rsp_did_scroll),
      .rsp_cell_value      (rsp_cell_value),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .pready              (pready),
      .fail_count          (fail_count),
      .expected_left       (expected_left)
   );

   always begin
      clock = 1'b0;
      #(CLOCK_PERIOD / 2);
      clock = 1'b1;
      #(CLOCK_PERIOD / 2);
   end

   // last cursor seen, used to aim reads at freshly written cells
   always @(posedge clock) begin
      if (rsp_valid) begin
         result_count  <= result_count + 1;
         last_position <= rsp_cursor_position;
      end
   end

   task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch,
                               input logic [10:0] index);
      int unsigned gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 12);
         if ($urandom_range(0, 15) == 0)
            burst_left = $urandom_range(5, 30);
      end
      repeat (gap) @(negedge clock);
      @(negedge clock);
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_char_code  <= ch;
      req_read_index <= index;
      // busy only moves at the rising edge
      while (busy !== 1'b0) @(negedge clock);
      @(posedge clock);
      accepted_count++;
      if (cmd != CMD_UNUSED)
         item_count++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain_results();
      while (result_count != accepted_count) @(negedge clock);
   endtask

   task automatic write_attribute(input logic [7:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_TEXT_ATTRIBUTE, 2'b00};
      pwdata  <= {24'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      while (pready !== 1'b1) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      #(CLOCK_PERIOD * 11_000_000);
      $display("text_console_char_writer: mismatch");
      $finish;
   end

   initial begin
      int unsigned phase;
      int unsigned pick;
      int unsigned len;
      int unsigned k;
      int unsigned phase_target;
      logic [7:0]  ch;
      logic [10:0] index;

      reset          = 1'b1;
      start          = 1'b0;
      req_cmd        = CMD_PUT;
      req_char_code  = '0;
      req_read_index = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // wait out the clearing pass after reset
      @(negedge clock);
      while (busy !== 1'b0) @(negedge clock);

      // directed: reset contents, read range edges, unused command, cursor edges
      send_request(CMD_READ, 8'h00, 11'd0);
      send_request(CMD_READ, 8'hFF, 11'd1999);
      send_request(CMD_READ, 8'h00, 11'd2000);
      send_request(CMD_READ, 8'h00, 11'h7FF);
      send_request(CMD_UNUSED, 8'hFF, 11'h7FF);
      send_request(CMD_PUT, CH_BACKSPACE, 11'd0);
      send_request(CMD_PUT, 8'h41, 11'd0);
      send_request(CMD_PUT, 8'h00, 11'd0);
      send_request(CMD_PUT, 8'hFF, 11'h7FF);
      send_request(CMD_PUT, CH_BACKSPACE, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd1);
      send_request(CMD_READ, 8'h00, 11'd2);
      send_request(CMD_PUT, CH_NEWLINE, 11'd0);
      send_request(CMD_PUT, CH_BACKSPACE, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd79);
      send_request(CMD_PUT, 8'h7E, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd79);
      send_request(CMD_CLEAR, 8'h00, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd0);
      send_request(CMD_PUT, CH_BACKSPACE, 11'd0);

      for (phase = 0; phase < 5; phase++) begin
         drain_results();
         case (phase)
            0:       write_attribute(8'h00);
            1:       write_attribute(8'hFF);
            default: write_attribute(8'($urandom_range(0, 255)));
         endcase
         if (phase == 1 || phase == 3)
            send_request(CMD_CLEAR, 8'($urandom), 11'($urandom));
         phase_target = item_count + PHASE_ITEMS;
         while (item_count < phase_target) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
               // a line of text, now and then long enough to wrap
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170)
                                                 : $urandom_range(0, 20);
               repeat (len) begin
                  ch = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(32, 126));
                  send_request(CMD_PUT, ch, 11'($urandom));
               end
               if ($urandom_range(0, 4) != 0)
                  send_request(CMD_PUT, CH_NEWLINE, 11'($urandom));
            end else if (pick < 82) begin
               k = $urandom_range(1, 12);
               if ($urandom_range(0, 9) == 0)
                  index = 11'($urandom);
               else if (last_position >= k)
                  index = last_position - 11'(k);
               else
                  index = 11'($urandom_range(0, 1999));
               send_request(CMD_READ, 8'($urandom), index);
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 5))
                  send_request(CMD_PUT, CH_BACKSPACE, 11'($urandom));
            end else if (pick < 93) begin
               send_request(CMD_UNUSED, 8'($urandom), 11'($urandom));
            end else if (pick < 94) begin
               send_request(CMD_CLEAR, 8'($urandom), 11'($urandom));
            end else if (pick < 95) begin
               drain_results();
            end else begin
               send_request(2'($urandom), 8'($urandom), 11'($urandom));
            end
         end
      end

      drain_results();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && expected_left == 0)
         $display("text_console_char_writer: match");
      else
         $display("text_console_char_writer: mismatch");
      $finish;
   end

endmodule
